// ===== design/arpc_pkg.sv =====
package arpc_pkg;

  // operation select codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_CHECK  = 2'd1;
  localparam logic [1:0] FUNC_SAVE   = 2'd2;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [7:0]  OPCODE_REPLY  = 8'd2;

  // register map
  localparam int          PADDR_W        = 2;
  localparam logic [PADDR_W-1:0] REG_MY_IP_ADDR = 2'd0;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  typedef struct packed {
    logic [1:0]       func;
    logic [15:0]      ether_type;
    logic [7:0]       opcode_low;
    logic [IP_W-1:0]  target_ip;
    logic [IP_W-1:0]  src_ip;
    logic [MAC_W-1:0] src_mac;
    logic [IP_W-1:0]  query_ip;
  } req_t;

  typedef struct packed {
    logic             is_my_reply;
    logic             hit;
    logic [1:0]       hit_index;
    logic [MAC_W-1:0] hit_mac;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOKUP,
    ST_DONE
  } state_e;

endpackage

// ===== design/arpc_ifs.sv =====
interface arpc_req_if import arpc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/arpc_ram.sv =====
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/arp_reply_check_and_cache_unit.sv =====
// ARP reply checker with a small round-robin address cache of ENTRIES
// (IP, MAC) pairs held in one single-port-read RAM. A save request writes the
// sender pair at the round-robin pointer; a lookup scans the RAM one entry per
// cycle through its read port, stopping at the first match or after the last
// entry on a miss. One request is in work at a time; the next is accepted
// while the previous result still waits in the output register. Entries are
// marked empty at reset and read as IP 0 / MAC 0 until written, so no clearing
// pass is needed.
module arp_reply_check_and_cache_unit import arpc_pkg::*; #(
  parameter int ENTRIES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  arpc_req_if.sink           req_i,
  arpc_rsp_if.source         rsp_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  state_e state_q, state_d;

  logic [IP_W-1:0]   my_ip_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [AW-1:0]     wptr_q, wptr_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              chk_q, chk_d;
  logic              arp_ok_q, arp_ok_d;
  logic [IP_W-1:0]   op_ip_q, op_ip_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic                   acc;
  logic                   cfg_we;
  logic                   ram_we;
  logic [IP_W+MAC_W-1:0]  ram_wdata;
  logic [IP_W+MAC_W-1:0]  ram_rdata;
  logic [IP_W-1:0]        ent_ip;
  logic [MAC_W-1:0]       ent_mac;
  logic [IP_W-1:0]        cmp_a;
  logic                   eq;
  logic                   out_free;
  logic [AW+1:0]          idx_ext;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid & req_i.ready;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i & (paddr_i == REG_MY_IP_ADDR);
  assign prdata_o = (paddr_i == REG_MY_IP_ADDR) ? my_ip_q : '0;

  assign ram_we    = acc & (req_i.data.func == FUNC_SAVE);
  assign ram_wdata = {req_i.data.src_ip, req_i.data.src_mac};

  arpc_ram #(
    .WIDTH (IP_W + MAC_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // never-written entries read as zero
  assign ent_ip  = valid_q[cmp_idx_q] ? ram_rdata[IP_W+MAC_W-1:MAC_W] : '0;
  assign ent_mac = valid_q[cmp_idx_q] ? ram_rdata[MAC_W-1:0] : '0;

  // shared comparator: own address on check, stored entry on lookup
  assign cmp_a = (state_q == ST_CHECK) ? my_ip_q : ent_ip;
  assign eq    = (cmp_a == op_ip_q);

  assign out_free = ~out_valid_q | rsp_o.ready;
  assign idx_ext  = (AW + 2)'(cmp_idx_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (req_i.data.func == FUNC_CHECK) begin
            state_d = ST_CHECK;
          end else if (req_i.data.func == FUNC_LOOKUP) begin
            state_d = ST_LOOKUP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CHECK: state_d = ST_DONE;
      ST_LOOKUP: begin
        if (chk_q && (eq || cmp_idx_q == LAST)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_d     = valid_q;
    wptr_d      = wptr_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    chk_d       = chk_q;
    arp_ok_d    = arp_ok_q;
    op_ip_d     = op_ip_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~rsp_o.ready;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          op_ip_d  = (req_i.data.func == FUNC_CHECK) ? req_i.data.target_ip
                                                     : req_i.data.query_ip;
          arp_ok_d = (req_i.data.ether_type == ETHERTYPE_ARP) &&
                     (req_i.data.opcode_low == OPCODE_REPLY);
          idx_d    = '0;
          chk_d    = 1'b0;
          res_d    = '0;
          if (req_i.data.func == FUNC_SAVE) begin
            valid_d[wptr_q] = 1'b1;
            wptr_d = (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
          end
        end
      end
      ST_CHECK: begin
        res_d.is_my_reply = arp_ok_q & eq;
      end
      ST_LOOKUP: begin
        // read of entry idx issued now, compared next cycle
        chk_d     = 1'b1;
        cmp_idx_d = idx_q;
        idx_d     = (idx_q == LAST) ? idx_q : idx_q + AW'(1);
        if (chk_q && eq) begin
          res_d.hit       = 1'b1;
          res_d.hit_index = idx_ext[1:0];
          res_d.hit_mac   = ent_mac;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      my_ip_q     <= '0;
      valid_q     <= '0;
      wptr_q      <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      wptr_q      <= wptr_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        my_ip_q <= pwdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    arp_ok_q  <= arp_ok_d;
    op_ip_q   <= op_ip_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ===== sim/tb_arp_reply_check_and_cache_unit.sv =====
module tb_arp_reply_check_and_cache_unit;
  import arpc_pkg::*;

  localparam int ENTRIES = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 176;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               psel_i;
  logic               penable_i;
  logic               pwrite_i;
  logic [PADDR_W-1:0] paddr_i;
  logic [31:0]        pwdata_i;
  logic [31:0]        prdata_o;
  logic               pready_o;

  arpc_req_if req_if ();
  arpc_rsp_if rsp_if ();

  arp_reply_check_and_cache_unit #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // requests waiting for the driver, responses waiting for the DUT
  req_t arp_req_q[$];
  rsp_t arp_rsp_q[$];

  // shadow of the DUT: own address and the address cache
  logic [31:0] own_ip;
  logic [31:0] cache_ip[ENTRIES];
  logic [47:0] cache_mac[ENTRIES];
  int          save_ptr;
  logic [31:0] ip_pool[8];

  int unsigned send_idle_pct;
  int unsigned rcv_idle_pct;
  int items_queued;
  int items_accepted;
  int error_count;
  int idle_cycles;
  int n_saves, n_lookups, n_hits, n_checks, n_own_replies, n_unused, n_cfg;
  rsp_t want;

  task automatic report(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("MISMATCH t=%0t %s: got %0h, expected %0h", $time, what, got, exp_val);
    error_count++;
  endtask

  function automatic rsp_t predict_arp(req_t r);
    rsp_t o;
    o = '0;
    case (r.func)
      FUNC_CHECK: begin
        n_checks++;
        if (r.ether_type == ETHERTYPE_ARP && r.opcode_low == OPCODE_REPLY &&
            r.target_ip == own_ip) begin
          o.is_my_reply = 1'b1;
          n_own_replies++;
        end
      end
      FUNC_SAVE: begin
        cache_ip[save_ptr]  = r.src_ip;
        cache_mac[save_ptr] = r.src_mac;
        save_ptr = (save_ptr + 1) % ENTRIES;
        n_saves++;
      end
      FUNC_LOOKUP: begin
        n_lookups++;
        // scan downward so the lowest matching index wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (cache_ip[i] == r.query_ip) begin
            o.hit       = 1'b1;
            o.hit_index = i[1:0];
            o.hit_mac   = cache_mac[i];
          end
        end
        if (o.hit) n_hits++;
      end
      default: n_unused++;
    endcase
    return o;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 3) != 0) return ip_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic req_t mk_req(logic [1:0] f, logic [15:0] et, logic [7:0] op,
                                  logic [31:0] tip, logic [31:0] sip, logic [47:0] mac,
                                  logic [31:0] qip);
    req_t r;
    r.func       = f;
    r.ether_type = et;
    r.opcode_low = op;
    r.target_ip  = tip;
    r.src_ip     = sip;
    r.src_mac    = mac;
    r.query_ip   = qip;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) r.func = FUNC_SAVE;
    else if (sel < 75) r.func = FUNC_LOOKUP;
    else if (sel < 97) r.func = FUNC_CHECK;
    else r.func = FUNC_UNUSED;
    // mostly well-formed replies so checks pass the first compare
    r.ether_type = ($urandom_range(0, 3) != 0) ? ETHERTYPE_ARP : 16'($urandom);
    r.opcode_low = ($urandom_range(0, 3) != 0) ? OPCODE_REPLY : 8'($urandom);
    r.target_ip  = ($urandom_range(0, 2) != 0) ? own_ip : pick_ip();
    r.src_ip     = pick_ip();
    r.src_mac    = rand_mac();
    r.query_ip   = pick_ip();
    return r;
  endfunction

  task automatic push_req(req_t r);
    arp_req_q.push_back(r);
    items_queued++;
  endtask

  task automatic drain();
    while (items_accepted != items_queued || arp_rsp_q.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 4) @(posedge clk_i);
  endtask

  task automatic write_own_ip(logic [31:0] value);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= REG_MY_IP_ADDR;
    pwdata_i  <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    own_ip = value;
    // read back, straight into a new setup phase
    pwrite_i  <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (prdata_o !== value) report("my_ip readback", prdata_o, value);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    n_cfg++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (arp_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data  <= arp_req_q.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // monitor: check responses, then predict for newly accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (arp_rsp_q.size() == 0) begin
          report("response with none pending", rsp_if.data, '0);
        end else begin
          want = arp_rsp_q.pop_front();
          if (rsp_if.data.is_my_reply !== want.is_my_reply)
            report("is_my_reply", rsp_if.data.is_my_reply, want.is_my_reply);
          if (rsp_if.data.hit !== want.hit)
            report("hit", rsp_if.data.hit, want.hit);
          if (rsp_if.data.hit_index !== want.hit_index)
            report("hit_index", rsp_if.data.hit_index, want.hit_index);
          if (rsp_if.data.hit_mac !== want.hit_mac)
            report("hit_mac", rsp_if.data.hit_mac, want.hit_mac);
        end
      end
      if (req_if.valid && req_if.ready) begin
        arp_rsp_q.push_back(predict_arp(req_if.data));
        items_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] ip_a, ip_b;
    logic [47:0] mac_y;
    psel_i    = 1'b0;
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
    paddr_i   = '0;
    pwdata_i  = '0;
    rst_ni    = 1'b0;
    own_ip    = '0;
    save_ptr  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_ip[i]  = '0;
      cache_mac[i] = '0;
    end
    items_queued = 0;
    items_accepted = 0;
    error_count = 0;
    idle_cycles = 0;
    {n_saves, n_lookups, n_hits, n_checks, n_own_replies, n_unused, n_cfg} = '0;
    send_idle_pct = 9;
    rcv_idle_pct  = 81;
    ip_a  = 32'hC0A8_0A0B;
    ip_b  = 32'h0A00_00FE;
    mac_y = 48'h0200_5E10_2030;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cleared store: address 0 hits entry 0; own address still at its reset value
    push_req(mk_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, '0));
    push_req(mk_req(FUNC_LOOKUP, '1, '1, '1, '1, '1, '1));
    push_req(mk_req(FUNC_CHECK, ETHERTYPE_ARP, OPCODE_REPLY, '0, '1, '1, '1));
    drain();

    write_own_ip('1);
    push_req(mk_req(FUNC_CHECK, ETHERTYPE_ARP, OPCODE_REPLY, '1, '1, '1, '1));
    push_req(mk_req(FUNC_CHECK, 16'h0800, OPCODE_REPLY, '1, '0, '0, '0));
    push_req(mk_req(FUNC_CHECK, ETHERTYPE_ARP, 8'd1, '1, '0, '0, '0));
    push_req(mk_req(FUNC_CHECK, ETHERTYPE_ARP, 8'h82, '1, '0, '0, '0));
    push_req(mk_req(FUNC_CHECK, ETHERTYPE_ARP, OPCODE_REPLY, ip_a, '1, '1, '1));
    push_req(mk_req(FUNC_SAVE, '0, '0, '0, ip_a, '1, '0));
    push_req(mk_req(FUNC_SAVE, '1, '1, '1, '1, '0, '1));
    push_req(mk_req(FUNC_SAVE, '0, '0, '0, ip_a, 48'h0012_3456_789A, '0));
    push_req(mk_req(FUNC_SAVE, '0, '0, '0, '0, mac_y, '0));
    push_req(mk_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, ip_a));
    push_req(mk_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, '1));
    push_req(mk_req(FUNC_LOOKUP, '1, '1, '1, '1, '1, '0));
    push_req(mk_req(FUNC_UNUSED, ETHERTYPE_ARP, OPCODE_REPLY, '1, '1, '1, '1));
    // pointer wraps back to entry 0, so the first match for ip_a moves to entry 2
    push_req(mk_req(FUNC_SAVE, '0, '0, '0, ip_b, 48'hA5A5_5A5A_F00F, '0));
    push_req(mk_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, ip_a));
    push_req(mk_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, ip_b));
    push_req(mk_req(FUNC_LOOKUP, '0, '0, '0, '0, '0, 32'h1234_5678));
    push_req(mk_req(FUNC_CHECK, ETHERTYPE_ARP, OPCODE_REPLY, 32'h7FFF_FFFF, '0, '0, '0));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 9;  rcv_idle_pct = 81; write_own_ip('0); end
        1: begin send_idle_pct = 81; rcv_idle_pct = 9;  write_own_ip($urandom); end
        default: begin send_idle_pct = 0; rcv_idle_pct = 0; write_own_ip($urandom); end
      endcase
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      ip_pool[2] = own_ip;
      for (int i = 3; i < 8; i++) ip_pool[i] = $urandom;
      for (int n = 0; n < RAND_PER_PHASE; n++) push_req(rand_req());
      drain();
    end

    $display("Ran %0d requests: %0d saves, %0d lookups (%0d hits), %0d checks",
             items_accepted, n_saves, n_lookups, n_hits, n_checks);
    $display("%0d own replies, %0d unused selects, own address set %0d times; %0d mismatches",
             n_own_replies, n_unused, n_cfg, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/arpc_pkg.sv
design/arpc_ifs.sv
design/arpc_ram.sv
design/arp_reply_check_and_cache_unit.sv
sim/tb_arp_reply_check_and_cache_unit.sv
